// ===== sv/urhe_pkg.sv =====
// ----------------------------------------------------------------------------
// urhe_pkg: shared types and constants for the unary run header engine
// Header geometry, operation and status codes, cell control and scan result bundles.
// ----------------------------------------------------------------------------
package urhe_pkg;

    localparam int HEADER_BITS = 136;
    localparam int BLOCK_BITS  = 8;
    localparam int NUM_BLOCKS  = HEADER_BITS / BLOCK_BITS;
    localparam int POS_W       = 8;
    localparam int BLK_W       = 5;
    localparam int QUOT_W      = 5;
    localparam int COUNT_W     = 6;
    localparam int COUNT_MAX   = 63;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HEADER_BITS - 1);

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_ROT,
        CM_INS,
        CM_DEL
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t         mode;
        logic [POS_W-1:0]   end_pos;
        logic [POS_W-1:0]   end_m1;
    } cell_ctl_t;

    typedef struct packed {
        logic               found;
        logic               nonempty;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
    } scan_res_t;

endpackage

// ===== sv/unary_run_header_engine.sv =====
// ----------------------------------------------------------------------------
// unary_run_header_engine: unary run-length header with lookup/insert/remove
// A ring of 17 eight-bit cells holds the 136-bit header; a block-serial
// scanner locates the run, then the cells shift the tail.
//
//   channel  signals                                        dir
//   req      req_valid, req_stall, operation, quotient      in
//   rsp      rsp_valid, rsp_stall, run_nonempty,
//            run_start, run_end, status                     out
//
// A request passes through accept, a scan of every block while the cell ring
// rotates once, and an update step that also loads the result register.
// The update cycle waits while a previous result is still stalled.
// Reset clears the header and element count; no clearing pass is needed.
// req_stall is high after accept until the update cycle completes.
// ----------------------------------------------------------------------------
module unary_run_header_engine #(
    parameter int QUOTIENTS = 32,
    parameter int MAX_ITEMS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      operation,
    input  logic [urhe_pkg::QUOT_W-1:0]     quotient,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            run_nonempty,
    output logic [urhe_pkg::POS_W-1:0]      run_start,
    output logic [urhe_pkg::POS_W-1:0]      run_end,
    output logic [1:0]                      status
);
    import urhe_pkg::*;

    localparam int FULL_LIM  = (MAX_ITEMS < COUNT_MAX) ? MAX_ITEMS : COUNT_MAX;
    localparam int QTAB_SIZE = 1 << QUOT_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [BLK_W-1:0]   blk_cnt_reg, blk_cnt_next;
    logic [1:0]         op_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               rsp_valid_reg;
    logic               run_nonempty_reg;
    logic [POS_W-1:0]   run_start_reg;
    logic [POS_W-1:0]   run_end_reg;
    logic [1:0]         status_reg, status_next;

    logic [QUOT_W-1:0]     qmod_tab [QTAB_SIZE];
    logic [BLOCK_BITS-1:0] blk [NUM_BLOCKS];

    logic       req_fire;
    logic       apply_fire;
    logic       do_ins;
    logic       do_del;
    scan_res_t  res;
    cell_ctl_t  ctl;

    genvar gi;
    generate
        for (gi = 0; gi < QTAB_SIZE; gi++)
        begin : g_qtab
            assign qmod_tab[gi] = QUOT_W'(gi % QUOTIENTS);
        end

        for (gi = 0; gi < NUM_BLOCKS; gi++)
        begin : g_cell
            logic prev_b;
            logic next_b;
            if (gi == 0)
            begin : g_first
                assign prev_b = 1'b0;
            end
            else
            begin : g_mid_lo
                assign prev_b = blk[gi-1][BLOCK_BITS-1];
            end
            if (gi == NUM_BLOCKS - 1)
            begin : g_last
                assign next_b = 1'b0;
            end
            else
            begin : g_mid_hi
                assign next_b = blk[gi+1][0];
            end
            urhe_cell #(
                .IDX (gi)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .rot_in  (blk[(gi + 1) % NUM_BLOCKS]),
                .prev_in (prev_b),
                .next_in (next_b),
                .bits    (blk[gi])
            );
        end
    endgenerate

    assign req_stall  = (state_reg != S_IDLE);
    assign req_fire   = req_valid && !req_stall;
    assign apply_fire = (state_reg == S_APPLY) && (!rsp_valid_reg || !rsp_stall);

    urhe_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (req_fire),
        .q        (qmod_tab[quotient]),
        .step     (state_reg == S_SCAN),
        .blk_idx  (blk_cnt_reg),
        .blk_bits (blk[0]),
        .res      (res)
    );

    assign do_ins = apply_fire && (op_reg == OP_INSERT) && res.found &&
                    (count_reg < COUNT_W'(FULL_LIM));
    assign do_del = apply_fire && (op_reg == OP_REMOVE) && res.nonempty;

    always_comb
    begin
        ctl.end_pos = res.end_pos;
        ctl.end_m1  = res.end_pos - 1'b1;
        if (state_reg == S_SCAN)
            ctl.mode = CM_ROT;
        else if (do_ins)
            ctl.mode = CM_INS;
        else if (do_del)
            ctl.mode = CM_DEL;
        else
            ctl.mode = CM_HOLD;
    end

    always_comb
    begin
        status_next = ST_DONE;
        case (op_reg)
            OP_INSERT:
            begin
                if (!do_ins)
                    status_next = ST_FULL;
            end
            OP_REMOVE:
            begin
                if (!res.nonempty)
                    status_next = ST_EMPTY;
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        blk_cnt_next = blk_cnt_reg;
        count_next   = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (blk_cnt_reg == BLK_W'(NUM_BLOCKS - 1))
                begin
                    blk_cnt_next = '0;
                    state_next   = S_APPLY;
                end
                else
                begin
                    blk_cnt_next = blk_cnt_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                if (apply_fire)
                    state_next = S_IDLE;
                if (do_ins)
                    count_next = count_reg + 1'b1;
                else if (do_del && count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            blk_cnt_reg   <= '0;
            count_reg     <= '0;
            op_reg        <= OP_LOOKUP;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            blk_cnt_reg <= blk_cnt_next;
            count_reg   <= count_next;
            if (req_fire)
                op_reg <= operation;
            if (apply_fire)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            run_nonempty_reg <= res.nonempty;
            run_start_reg    <= res.start_pos;
            run_end_reg      <= res.end_pos;
            status_reg       <= status_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign run_nonempty = run_nonempty_reg;
    assign run_start    = run_start_reg;
    assign run_end      = run_end_reg;
    assign status       = status_reg;

`ifndef SYNTH
    a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_SCAN)
        else $error("accepted beat did not start a scan");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FULL_LIM))
        else $error("element count above limit");

    a_rsp_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_APPLY))
        else $error("result beat raised outside update cycle");

    a_idle_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_SCAN |-> blk_cnt_reg == '0)
        else $error("block counter not home outside scan");
`endif

endmodule

// ===== sv/urhe_cell.sv =====
// ----------------------------------------------------------------------------
// urhe_cell: one block of header bits
// Rotates its block to the neighbor during a scan, and shifts bits by one
// position around the run end on insert or remove.
// ----------------------------------------------------------------------------
module urhe_cell #(
    parameter int IDX = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  urhe_pkg::cell_ctl_t                 ctl,
    input  logic [urhe_pkg::BLOCK_BITS-1:0]     rot_in,
    input  logic                                prev_in,
    input  logic                                next_in,
    output logic [urhe_pkg::BLOCK_BITS-1:0]     bits
);
    import urhe_pkg::*;

    localparam int BASE = IDX * BLOCK_BITS;

    logic [BLOCK_BITS-1:0] bits_reg;
    logic [BLOCK_BITS-1:0] bits_next;
    logic [BLOCK_BITS+1:0] ext;

    assign ext  = {next_in, bits_reg, prev_in};
    assign bits = bits_reg;

    always_comb
    begin
        bits_next = bits_reg;
        case (ctl.mode)
            CM_ROT:
            begin
                bits_next = rot_in;
            end
            CM_INS:
            begin
                for (int j = 0; j < BLOCK_BITS; j++)
                begin
                    if (POS_W'(BASE + j) > ctl.end_pos)
                        bits_next[j] = ext[j];
                    else if (POS_W'(BASE + j) == ctl.end_pos)
                        bits_next[j] = 1'b1;
                end
            end
            CM_DEL:
            begin
                for (int j = 0; j < BLOCK_BITS; j++)
                begin
                    if (POS_W'(BASE + j) >= ctl.end_m1)
                        bits_next[j] = ext[j+2];
                end
            end
            default:
            begin
                bits_next = bits_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bits_reg <= '0;
        else
            bits_reg <= bits_next;
    end

endmodule

// ===== sv/urhe_scan.sv =====
// ----------------------------------------------------------------------------
// urhe_scan: block-serial run locator
// Takes one header block per cycle, counts zeros to find the run start
// and then the first zero at or after it.
// ----------------------------------------------------------------------------
module urhe_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                init,
    input  logic [urhe_pkg::QUOT_W-1:0]         q,
    input  logic                                step,
    input  logic [urhe_pkg::BLK_W-1:0]          blk_idx,
    input  logic [urhe_pkg::BLOCK_BITS-1:0]     blk_bits,
    output urhe_pkg::scan_res_t                 res
);
    import urhe_pkg::*;

    logic [QUOT_W-1:0] q_reg;
    logic [QUOT_W-1:0] zc_reg, zc_next;
    logic              hs_reg, hs_next;
    logic [POS_W-1:0]  st_reg, st_next;
    logic              he_reg, he_next;
    logic [POS_W-1:0]  en_reg, en_next;
    logic              start_ok;

    always_comb
    begin
        logic [POS_W-1:0] p;
        zc_next = zc_reg;
        hs_next = hs_reg;
        st_next = st_reg;
        he_next = he_reg;
        en_next = en_reg;
        p       = '0;
        for (int j = 0; j < BLOCK_BITS; j++)
        begin
            p = {blk_idx, 3'(j)};
            if (!hs_next)
            begin
                if (!blk_bits[j])
                begin
                    zc_next = zc_next + 1'b1;
                    if (zc_next == q_reg)
                    begin
                        hs_next = 1'b1;
                        st_next = p + 1'b1;
                    end
                end
            end
            else if (!he_next && !blk_bits[j] && p >= st_next)
            begin
                he_next = 1'b1;
                en_next = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= '0;
            zc_reg <= '0;
            hs_reg <= 1'b0;
            st_reg <= '0;
            he_reg <= 1'b0;
            en_reg <= '0;
        end
        else if (init)
        begin
            q_reg  <= q;
            zc_reg <= '0;
            hs_reg <= (q == '0);
            st_reg <= '0;
            he_reg <= 1'b0;
            en_reg <= '0;
        end
        else if (step)
        begin
            zc_reg <= zc_next;
            hs_reg <= hs_next;
            st_reg <= st_next;
            he_reg <= he_next;
            en_reg <= en_next;
        end
    end

    assign start_ok      = hs_reg && (st_reg < POS_W'(HEADER_BITS));
    assign res.found     = start_ok && he_reg;
    assign res.start_pos = start_ok ? st_reg : LAST_POS;
    assign res.end_pos   = (start_ok && he_reg) ? en_reg : LAST_POS;
    assign res.nonempty  = start_ok && he_reg && (st_reg != en_reg);

endmodule
